### rtl/assert_macros.svh
// Assertion macros for the rate limiter checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/gwtb_pkg.sv
`default_nettype none
package gwtb_pkg;

  localparam int FLOW_ENTRIES_DEF = 16;

  localparam int KEY_W     = 32;
  localparam int TICK_W    = 32;
  localparam int MAXTOK_W  = 16;
  localparam int RATE_W    = 32;
  localparam int LIMIT_W   = 24;
  localparam int LEVEL_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [MAXTOK_W-1:0] MAX_TOKENS_RST = 16'd10;
  localparam logic [RATE_W-1:0]   REFILL_RST     = 32'd66;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST      = 24'd1000;
  localparam logic [TICK_W-1:0]   WINDOW_RST     = 32'd1000000;

  localparam logic [LEVEL_W-1:0] ONE_TOKEN = 32'h0001_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKENS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd3;

  typedef logic [1:0] verdict_t;
  localparam verdict_t V_ADMIT  = 2'd0;
  localparam verdict_t V_GLOBAL = 2'd1;
  localparam verdict_t V_FLOW   = 2'd2;
  localparam verdict_t V_FULL   = 2'd3;

endpackage
`default_nettype wire

### rtl/global_window_and_per_flow_token_bucket.sv
// channel  | valid     | ready     | payload
// ---------+-----------+-----------+------------------------------------
// in       | in_valid  | in_ready  | in_flow_key, in_now_ticks
// out      | out_valid | out_ready | out_allowed, out_verdict
// cfg      | cfg_we    | (none)    | cfg_index, cfg_data
//
// One item at a time. A global denial goes from the window check straight to the
// output; otherwise the flow table is scanned key by key, a full table with no match
// is refused, and a stored or new flow passes the load, multiply, sum and finish states.
// Reset (rst_n low, synchronous) clears the window, the flow count and the
// handshakes, and loads the register defaults.
// A result waiting on out_ready holds the next item off only once it is done.
`default_nettype none
module global_window_and_per_flow_token_bucket #(
  parameter int FLOW_ENTRIES = gwtb_pkg::FLOW_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [gwtb_pkg::KEY_W-1:0]     in_flow_key,
  input  wire logic [gwtb_pkg::TICK_W-1:0]    in_now_ticks,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_allowed,
  output gwtb_pkg::verdict_t                  out_verdict,
  input  wire logic                           cfg_we,
  input  wire logic [gwtb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gwtb_pkg::CFG_DAT_W-1:0] cfg_data
);
  import gwtb_pkg::*;

  localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CW = $clog2(FLOW_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(FLOW_ENTRIES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GLOB = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [KEY_W-1:0]             key_mem [FLOW_ENTRIES];
  logic [LEVEL_W+TICK_W-1:0]    bkt_mem [FLOW_ENTRIES];
  logic [KEY_W-1:0]             key_rd_r;
  logic [LEVEL_W+TICK_W-1:0]    bkt_rd_r;

  logic [2:0]          state_r, state_nxt;
  logic [MAXTOK_W-1:0] max_tok_r;
  logic [RATE_W-1:0]   refill_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [TICK_W-1:0]   window_r;
  logic [LIMIT_W-1:0]  win_cnt_r, win_cnt_nxt;
  logic [TICK_W-1:0]   win_start_r, win_start_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic                ins_r, ins_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [TICK_W-1:0]   now_r, now_nxt;
  logic [LEVEL_W-1:0]  lvl_r, lvl_nxt;
  logic [TICK_W-1:0]   el_r, el_nxt;
  logic [63:0]         prod_r, prod_nxt;
  logic [LEVEL_W-1:0]  lvlc_r, lvlc_nxt;
  verdict_t            verd_r, verd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_allowed_r, out_allowed_nxt;
  verdict_t            out_verdict_r, out_verdict_nxt;

  logic                      key_re, key_we, bkt_re, bkt_we;
  logic [IW-1:0]             key_ra, bkt_ra;
  logic [LEVEL_W+TICK_W-1:0] bkt_wd;

  logic [TICK_W-1:0]   win_elapsed;
  logic                win_restart;
  logic                glob_deny;
  logic [LIMIT_W-1:0]  cnt_eff;
  logic [64:0]         sum;
  logic [64:0]         cap;
  logic                out_free;

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;
  assign out_verdict = out_verdict_r;

  assign win_elapsed = now_r - win_start_r;
  assign win_restart = (win_elapsed >= window_r);
  assign cnt_eff     = win_restart ? '0 : win_cnt_r;
  assign glob_deny   = (cnt_eff >= limit_r);
  assign sum         = {33'd0, lvl_r} + {1'b0, prod_r};
  assign cap         = {33'd0, max_tok_r, 16'd0};
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    win_cnt_nxt     = win_cnt_r;
    win_start_nxt   = win_start_r;
    fill_nxt        = fill_r;
    idx_nxt         = idx_r;
    rd_idx_nxt      = rd_idx_r;
    rd_pend_nxt     = rd_pend_r;
    slot_nxt        = slot_r;
    ins_nxt         = ins_r;
    key_nxt         = key_r;
    now_nxt         = now_r;
    lvl_nxt         = lvl_r;
    el_nxt          = el_r;
    prod_nxt        = prod_r;
    lvlc_nxt        = lvlc_r;
    verd_nxt        = verd_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_allowed_nxt = out_allowed_r;
    out_verdict_nxt = out_verdict_r;
    key_re          = 1'b0;
    key_ra          = idx_r[IW-1:0];
    key_we          = 1'b0;
    bkt_re          = 1'b0;
    bkt_ra          = rd_idx_r;
    bkt_we          = 1'b0;
    bkt_wd          = {lvlc_r, now_r};
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_flow_key;
          now_nxt   = in_now_ticks;
          state_nxt = ST_GLOB;
        end
      end
      ST_GLOB: begin
        if (win_restart) begin
          win_start_nxt = now_r;
        end
        idx_nxt     = '0;
        rd_pend_nxt = 1'b0;
        if (glob_deny) begin
          win_cnt_nxt = cnt_eff;
          verd_nxt    = V_GLOBAL;
          state_nxt   = ST_OUT;
        end else begin
          win_cnt_nxt = cnt_eff + 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_pend_r && key_rd_r == key_r) begin
          slot_nxt    = rd_idx_r;
          ins_nxt     = 1'b0;
          bkt_re      = 1'b1;
          rd_pend_nxt = 1'b0;
          state_nxt   = ST_LOAD;
        end else if (idx_r < fill_r) begin
          key_re      = 1'b1;
          rd_idx_nxt  = idx_r[IW-1:0];
          rd_pend_nxt = 1'b1;
          idx_nxt     = idx_r + 1'b1;
        end else if (rd_pend_r) begin
          rd_pend_nxt = 1'b0;
        end else if (fill_r == FULL_CNT) begin
          verd_nxt  = V_FULL;
          state_nxt = ST_OUT;
        end else begin
          key_we    = 1'b1;
          slot_nxt  = fill_r[IW-1:0];
          ins_nxt   = 1'b1;
          fill_nxt  = fill_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (ins_r) begin
          lvl_nxt = {max_tok_r, 16'd0};
          el_nxt  = '0;
        end else begin
          lvl_nxt = bkt_rd_r[LEVEL_W+TICK_W-1:TICK_W];
          el_nxt  = now_r - bkt_rd_r[TICK_W-1:0];
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = el_r * refill_r;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        lvlc_nxt  = (sum > cap) ? cap[LEVEL_W-1:0] : sum[LEVEL_W-1:0];
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        bkt_we = 1'b1;
        if (lvlc_r < ONE_TOKEN) begin
          bkt_wd   = {lvlc_r, now_r};
          verd_nxt = V_FLOW;
        end else begin
          bkt_wd   = {lvlc_r - ONE_TOKEN, now_r};
          verd_nxt = V_ADMIT;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = (verd_r == V_ADMIT);
          out_verdict_nxt = verd_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[slot_nxt] <= key_r;
    end
    if (key_re) begin
      key_rd_r <= key_mem[key_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[slot_r] <= bkt_wd;
    end
    if (bkt_re) begin
      bkt_rd_r <= bkt_mem[bkt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      max_tok_r     <= MAX_TOKENS_RST;
      refill_r      <= REFILL_RST;
      limit_r       <= LIMIT_RST;
      window_r      <= WINDOW_RST;
      win_cnt_r     <= '0;
      win_start_r   <= '0;
      fill_r        <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_cnt_r   <= win_cnt_nxt;
      win_start_r <= win_start_nxt;
      fill_r      <= fill_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_TOKENS: max_tok_r <= cfg_data[MAXTOK_W-1:0];
          CFG_REFILL:     refill_r  <= cfg_data[RATE_W-1:0];
          CFG_LIMIT:      limit_r   <= cfg_data[LIMIT_W-1:0];
          CFG_WINDOW:     window_r  <= cfg_data[TICK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    rd_idx_r      <= rd_idx_nxt;
    slot_r        <= slot_nxt;
    ins_r         <= ins_nxt;
    key_r         <= key_nxt;
    now_r         <= now_nxt;
    lvl_r         <= lvl_nxt;
    el_r          <= el_nxt;
    prod_r        <= prod_nxt;
    lvlc_r        <= lvlc_nxt;
    verd_r        <= verd_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

endmodule
`default_nettype wire

### rtl/gwtb_chk.sv
`default_nettype none
`include "assert_macros.svh"
module gwtb_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_allowed,
  input wire gwtb_pkg::verdict_t out_verdict
);
  import gwtb_pkg::*;

  `ASSERT_CLK(a_allowed_matches_verdict, out_valid |-> (out_allowed == (out_verdict == V_ADMIT)), "allowed disagrees with verdict")
  `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_verdict)), "result dropped or changed while stalled")
  `ASSERT_CLK(a_one_item_in_flight, (in_valid && in_ready) |=> !in_ready, "second item accepted while one is in work")
  `ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result shown right after reset")

endmodule

bind global_window_and_per_flow_token_bucket gwtb_chk u_gwtb_chk (.*);
`default_nettype wire
